// ----- sv/sfr_pkg.sv -----
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int ENTRY_REGS      = 4;
   localparam int TYPE_COUNT_DEF  = 4;
   localparam int ADDR_W          = 5;
   localparam int DATA_W          = 32;
   localparam int ENTRY_W         = 24;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [7:0]  SYNC_RESET = 8'h73;

   localparam logic [2:0] REG_SYNC    = 3'd0;
   localparam logic [2:0] REG_ENTRY_0 = 3'd1;
   localparam logic [2:0] REG_ENTRY_1 = 3'd2;
   localparam logic [2:0] REG_ENTRY_2 = 3'd3;
   localparam logic [2:0] REG_ENTRY_3 = 3'd4;

   localparam logic [1:0] STATUS_NONE    = 2'd0;
   localparam logic [1:0] STATUS_GOOD    = 2'd1;
   localparam logic [1:0] STATUS_CRC_ERR = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [7:0]                             sync_char;
      logic [ENTRY_REGS-1:0][ENTRY_W-1:0]     type_entry;
   } cfg_type;

   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- sv/sfr_csr.sv -----
`timescale 1ns / 1ps

module sfr_csr
   import sfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic [2:0]  index;
   logic        write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[ADDR_W-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_SYNC:    cfg_in.sync_char     = csr_pwdata[7:0];
            REG_ENTRY_0: cfg_in.type_entry[0] = csr_pwdata[ENTRY_W-1:0];
            REG_ENTRY_1: cfg_in.type_entry[1] = csr_pwdata[ENTRY_W-1:0];
            REG_ENTRY_2: cfg_in.type_entry[2] = csr_pwdata[ENTRY_W-1:0];
            REG_ENTRY_3: cfg_in.type_entry[3] = csr_pwdata[ENTRY_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_SYNC:    csr_prdata = {24'h0, cfg_ff.sync_char};
         REG_ENTRY_0: csr_prdata = {8'h0, cfg_ff.type_entry[0]};
         REG_ENTRY_1: csr_prdata = {8'h0, cfg_ff.type_entry[1]};
         REG_ENTRY_2: csr_prdata = {8'h0, cfg_ff.type_entry[2]};
         REG_ENTRY_3: csr_prdata = {8'h0, cfg_ff.type_entry[3]};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_char  <= SYNC_RESET;
         cfg_ff.type_entry <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/sfr_core.sv -----
`timescale 1ns / 1ps

module sfr_core
   import sfr_pkg::*;
#(
   parameter int TYPE_COUNT = TYPE_COUNT_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic [4:0]  rsp_tuser
);

   localparam int USED = (TYPE_COUNT < ENTRY_REGS) ? TYPE_COUNT : ENTRY_REGS;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_data_ff, out_data_in;
   logic [4:0]  out_user_ff, out_user_in;

   logic        in_sync_ff, in_sync_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  frame_len_ff, frame_len_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  first_ff, first_in;
   logic [15:0] crc_ff, crc_in;

   logic        advance;
   logic        out_free;

   logic        stored;
   logic [7:0]  pos;
   logic [1:0]  status;
   logic [1:0]  kind;
   logic        fresh;
   logic [15:0] crc_upd;
   logic [7:0]  first_cur;
   logic [8:0]  n;
   logic        found;
   logic [1:0]  match_kind;
   logic [7:0]  match_len;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;

   assign fresh     = !in_sync_ff || (byte_count_ff == 8'd0);
   assign crc_upd   = crc_next(fresh ? CRC_INIT : crc_ff, in_byte_ff);
   assign first_cur = fresh ? in_byte_ff : first_ff;
   assign n         = {1'b0, byte_count_ff} + 9'd1;

   always_comb begin
      found      = 1'b0;
      match_kind = 2'd0;
      match_len  = 8'd0;
      for (int i = USED - 1; i >= 0; i--) begin
         if (cfg.type_entry[i][23:16] == first_cur && cfg.type_entry[i][15:8] == in_byte_ff) begin
            found      = 1'b1;
            match_kind = 2'(i);
            match_len  = cfg.type_entry[i][7:0];
         end
      end
   end

   always_comb begin
      stored        = 1'b0;
      pos           = 8'd0;
      status        = STATUS_NONE;
      kind          = 2'd0;
      in_sync_in    = in_sync_ff;
      byte_count_in = byte_count_ff;
      frame_len_in  = frame_len_ff;
      kind_in       = kind_ff;
      first_in      = first_ff;
      crc_in        = crc_ff;
      if (!in_sync_ff) begin
         if (in_byte_ff == cfg.sync_char) begin
            in_sync_in    = 1'b1;
            stored        = 1'b1;
            first_in      = in_byte_ff;
            crc_in        = crc_upd;
            byte_count_in = 8'd1;
         end
      end else begin
         stored        = 1'b1;
         pos           = byte_count_ff;
         first_in      = first_cur;
         crc_in        = crc_upd;
         byte_count_in = n[8] ? 8'hFF : n[7:0];
         if (n == 9'd2) begin
            if (found) begin
               kind_in      = match_kind;
               frame_len_in = match_len;
            end else begin
               status        = STATUS_UNKNOWN;
               in_sync_in    = 1'b0;
               byte_count_in = 8'd0;
               crc_in        = CRC_INIT;
            end
         end
         if (status != STATUS_UNKNOWN && n >= 9'd2) begin
            kind = kind_in;
            if (frame_len_in != 8'd0 && n >= {1'b0, frame_len_in}) begin
               if (crc_upd == 16'h0000) begin
                  status = STATUS_GOOD;
               end else begin
                  status     = STATUS_CRC_ERR;
                  in_sync_in = 1'b0;
               end
               byte_count_in = 8'd0;
               crc_in        = CRC_INIT;
            end
         end
      end
   end

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      out_data_in = {in_byte_ff, pos};
      out_user_in = {kind, status, stored};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         in_sync_ff    <= 1'b0;
         byte_count_ff <= 8'd0;
         frame_len_ff  <= 8'd0;
         kind_ff       <= 2'd0;
         first_ff      <= 8'd0;
         crc_ff        <= CRC_INIT;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            in_sync_ff    <= in_sync_in;
            byte_count_ff <= byte_count_in;
            frame_len_ff  <= frame_len_in;
            kind_ff       <= kind_in;
            first_ff      <= first_in;
            crc_ff        <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// ----- sv/serial_frame_receiver_crc16_top.sv -----
`timescale 1ns / 1ps
// A byte accepted is held in the input register; its result is held in the output register.
// Throughput: one byte per cycle while the result side accepts, set by the combinational CRC and type match logic.
// An input register and an output register let a new byte enter while a result waits.
// Reset clears the frame state to hunting, sets the sync character to 's' and
// clears all type entries.

module serial_frame_receiver_crc16_top
   import sfr_pkg::*;
#(
   parameter int TYPE_COUNT = TYPE_COUNT_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // rx_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,   // position, frame_byte
   output logic [4:0]        rsp_tuser,   // stored, status, frame_kind
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type cfg;

   sfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sfr_core #(
      .TYPE_COUNT (TYPE_COUNT)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- sim/tb_serial_frame_receiver_crc16_top.sv -----
`timescale 1ns / 1ps

module tb_serial_frame_receiver_crc16_top;
   import sfr_pkg::*;

   localparam int ACTIVE_ENTRIES = (TYPE_COUNT_DEF < ENTRY_REGS) ? TYPE_COUNT_DEF : ENTRY_REGS;
   localparam int LAST_ADDR_REG  = (1 << ADDR_W) / 4 - 1;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct {
      bit          in_sync;
      bit [7:0]    count;
      bit [7:0]    len;
      bit [1:0]    kind;
      bit [7:0]    first;
      bit [15:0]   crc;
   } deframer_state_type;

   typedef struct {
      bit          stored;
      bit [7:0]    position;
      bit [7:0]    frame_byte;
      bit [1:0]    status;
      bit [1:0]    frame_kind;
   } byte_report_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = '0;    // rx_byte
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [15:0]       rsp_tdata;         // position, frame_byte
   logic [4:0]        rsp_tuser;         // stored, status, frame_kind
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   cfg_type            csr_shadow;
   deframer_state_type model_state;
   deframer_state_type stim_state;
   logic [7:0]         pending_bytes[$];
   byte_report_type    expected_reports[$];
   int                 send_idle;
   int                 recv_idle;
   int                 byte_total;
   int                 error_count;

   serial_frame_receiver_crc16_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   function automatic bit [15:0] crc16_update(bit [15:0] crc, bit [7:0] b);
      bit [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   function automatic deframer_state_type hunting_state();
      deframer_state_type st;
      st = '{default: 0};
      st.crc = CRC_INIT;
      return st;
   endfunction

   function automatic byte_report_type decode_byte(inout deframer_state_type st,
                                                   input cfg_type cfg, input bit [7:0] b);
      byte_report_type r;
      int              n;
      bit              found;
      r = '{default: 0};
      r.frame_byte = b;
      if (!st.in_sync) begin
         if (b == cfg.sync_char) begin
            st.in_sync = 1'b1;
            r.stored   = 1'b1;
            st.first   = b;
            st.crc     = crc16_update(CRC_INIT, b);
            st.count   = 8'd1;
         end
      end else begin
         r.stored   = 1'b1;
         r.position = st.count;
         if (st.count == 0) begin
            st.crc   = crc16_update(CRC_INIT, b);
            st.first = b;
         end else begin
            st.crc = crc16_update(st.crc, b);
         end
         n = int'(st.count) + 1;
         st.count = (n > 255) ? 8'd255 : 8'(n);
         if (n == 2) begin
            found = 1'b0;
            for (int k = 0; k < ACTIVE_ENTRIES && !found; k++) begin
               if (cfg.type_entry[k][23:16] == st.first && cfg.type_entry[k][15:8] == b) begin
                  st.kind = 2'(k);
                  st.len  = cfg.type_entry[k][7:0];
                  found   = 1'b1;
               end
            end
            if (!found) begin
               r.status   = STATUS_UNKNOWN;
               st.in_sync = 1'b0;
               st.count   = 8'd0;
               st.crc     = CRC_INIT;
            end
         end
         if (r.status != STATUS_UNKNOWN && n >= 2) begin
            r.frame_kind = st.kind;
            if (st.len != 0 && n >= int'(st.len)) begin
               if (st.crc == 16'h0000) begin
                  r.status = STATUS_GOOD;
               end else begin
                  r.status   = STATUS_CRC_ERR;
                  st.in_sync = 1'b0;
               end
               st.count = 8'd0;
               st.crc   = CRC_INIT;
            end
         end
      end
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Byte source: holds or advances the request transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_bytes.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      byte_report_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_reports.push_back(decode_byte(model_state, csr_shadow, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               $error("result transaction with nothing expected: tdata 0x%0h tuser 0x%0h",
                      rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("stored", 8'(want.stored), 8'(rsp_tuser[0]));
               check_field("position", want.position, rsp_tdata[7:0]);
               check_field("frame_byte", want.frame_byte, rsp_tdata[15:8]);
               check_field("status", 8'(want.status), 8'(rsp_tuser[2:1]));
               check_field("frame_kind", 8'(want.frame_kind), 8'(rsp_tuser[4:3]));
            end
         end
      end
   end

   task automatic csr_write(input int idx, input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(idx * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_SYNC) begin
         csr_shadow.sync_char = data[7:0];
      end else if (idx <= REG_ENTRY_3) begin
         csr_shadow.type_entry[idx - REG_ENTRY_0] = data[ENTRY_W-1:0];
      end
   endtask

   task automatic set_sync(input logic [7:0] ch);
      csr_write(REG_SYNC, {24'($urandom), ch});
   endtask

   task automatic set_entry(input int k, input logic [7:0] t0, input logic [7:0] t1,
                            input logic [7:0] len);
      csr_write(REG_ENTRY_0 + k, {8'($urandom), t0, t1, len});
   endtask

   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      void'(decode_byte(stim_state, csr_shadow, b));
      byte_total++;
   endtask

   // Builds one frame for entry k; the two trailing bytes carry the CRC so that
   // an uncorrupted frame of length four or more leaves a zero residue.
   task automatic push_frame(input int k, input bit corrupt);
      logic [7:0]  frame_bytes[$];
      logic [15:0] c;
      int          len;
      int          pos;
      len = csr_shadow.type_entry[k][7:0];
      frame_bytes = {csr_shadow.type_entry[k][23:16], csr_shadow.type_entry[k][15:8]};
      if (len == 3) begin
         frame_bytes.push_back(8'($urandom));
      end else if (len >= 4) begin
         while (frame_bytes.size() < len - 2) frame_bytes.push_back(8'($urandom));
         c = CRC_INIT;
         foreach (frame_bytes[i]) c = crc16_update(c, frame_bytes[i]);
         frame_bytes.push_back(c[15:8]);
         frame_bytes.push_back(c[7:0]);
      end
      if (corrupt) begin
         pos = (frame_bytes.size() > 2) ? $urandom_range(2, frame_bytes.size() - 1) : 1;
         frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
      end
      foreach (frame_bytes[i]) push_byte(frame_bytes[i]);
   endtask

   task automatic random_traffic(input int count);
      int         target;
      int         r;
      int         k;
      logic [23:0] e;
      target = byte_total + count;
      while (byte_total < target) begin
         r = $urandom_range(0, 99);
         if (stim_state.in_sync && stim_state.count != 0) begin
            push_byte(8'($urandom));
         end else if (r < 70) begin
            k = 0;
            for (int t = 0; t < 8; t++) begin
               k = $urandom_range(0, ACTIVE_ENTRIES - 1);
               e = csr_shadow.type_entry[k];
               if (e[7:0] != 0 && (stim_state.in_sync || e[23:16] == csr_shadow.sync_char)) break;
            end
            e = csr_shadow.type_entry[k];
            if (e[7:0] == 0 || (!stim_state.in_sync && e[23:16] != csr_shadow.sync_char)) begin
               push_byte(csr_shadow.sync_char);
            end else if (e[7:0] > 64 && $urandom_range(0, 7) != 0) begin
               push_byte(8'($urandom));
            end else begin
               push_frame(k, $urandom_range(0, 99) < 15);
            end
         end else if (r < 85) begin
            push_byte(csr_shadow.sync_char);
            push_byte(8'($urandom));
         end else begin
            push_byte(($urandom_range(0, 3) == 0) ? csr_shadow.sync_char : 8'($urandom));
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_tvalid || expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [7:0] x;
      logic [7:0] s;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      send_idle   = 32;
      recv_idle   = 62;
      byte_total  = 0;
      error_count = 0;
      model_state = hunting_state();
      stim_state  = hunting_state();
      csr_shadow.sync_char  = SYNC_RESET;
      csr_shadow.type_entry = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Values after reset: the sync character starts a frame, no type is known.
      push_byte(8'h5A);
      push_byte(SYNC_RESET);
      push_byte(8'h00);
      wait_drained();

      for (int i = REG_ENTRY_3 + 1; i <= LAST_ADDR_REG; i++) csr_write(i, $urandom);
      set_sync(8'h73);
      set_entry(0, 8'h73, 8'h01, 8'd5);
      set_entry(1, 8'h73, 8'h01, 8'd9);
      set_entry(2, 8'hA5, 8'h5A, 8'd1);
      set_entry(3, 8'h73, 8'h02, 8'd2);
      push_frame(0, 1'b0);
      push_frame(2, 1'b0);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_frame(3, 1'b0);
      push_byte(8'h73);
      push_byte(8'h99);
      push_frame(0, 1'b0);
      push_byte(8'h11);
      push_byte(8'h22);
      push_frame(0, 1'b1);
      wait_drained();

      set_sync(8'h73);
      set_entry(0, 8'h73, 8'h10, 8'($urandom_range(4, 20)));
      set_entry(1, 8'h73, 8'h20, 8'($urandom_range(3, 30)));
      set_entry(2, 8'($urandom), 8'($urandom), 8'($urandom_range(5, 40)));
      set_entry(3, 8'($urandom), 8'($urandom), 8'd3);
      random_traffic(200);
      wait_drained();

      send_idle = 62;
      recv_idle = 32;
      set_sync(8'h00);
      set_entry(0, 8'h00, 8'h00, 8'd12);
      set_entry(1, 8'h00, 8'hFF, 8'd255);
      set_entry(2, 8'hFF, 8'h00, 8'($urandom_range(1, 30)));
      set_entry(3, 8'h00, 8'($urandom), 8'($urandom_range(4, 16)));
      push_byte(8'h00);
      push_byte(8'hFF);
      repeat (251) push_byte(8'($urandom));
      random_traffic(150);
      wait_drained();

      x = 8'($urandom);
      set_sync(8'hFF);
      set_entry(0, 8'hFF, 8'($urandom), 8'($urandom_range(1, 2)));
      set_entry(1, 8'hFF, x, 8'($urandom_range(6, 14)));
      set_entry(2, 8'($urandom), 8'($urandom), 8'($urandom_range(3, 20)));
      set_entry(3, 8'hFF, x, 8'($urandom_range(20, 30)));
      random_traffic(150);
      wait_drained();

      send_idle = 0;
      recv_idle = 0;
      s = 8'($urandom);
      set_sync(s);
      set_entry(0, s, 8'($urandom), 8'($urandom_range(1, 24)));
      set_entry(1, s, 8'($urandom), 8'($urandom_range(3, 24)));
      set_entry(2, 8'($urandom), 8'($urandom), 8'($urandom_range(3, 24)));
      set_entry(3, 8'($urandom), 8'($urandom), 8'($urandom_range(3, 24)));
      random_traffic(170);
      wait_drained();

      // A zero-length type never closes its frame, so this phase comes last.
      set_sync(8'h73);
      set_entry(0, 8'h73, 8'h01, 8'd0);
      set_entry(1, 8'h73, 8'($urandom_range(2, 255)), 8'($urandom_range(3, 20)));
      set_entry(2, 8'($urandom), 8'($urandom), 8'($urandom_range(3, 20)));
      set_entry(3, 8'($urandom), 8'($urandom), 8'($urandom_range(3, 20)));
      random_traffic(100);
      while (stim_state.in_sync && stim_state.count != 0 &&
             !(stim_state.count >= 2 && stim_state.len == 0)) begin
         push_byte(8'($urandom));
      end
      push_byte(8'h73);
      push_byte(8'h01);
      repeat (280) push_byte(8'($urandom));
      wait_drained();

      if (error_count == 0) begin
         $display("tb_serial_frame_receiver_crc16_top: clean");
      end else begin
         $display("tb_serial_frame_receiver_crc16_top: errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_serial_frame_receiver_crc16_top: errors");
      $finish;
   end

endmodule
